// ===== design/smt_pkg.sv =====
`timescale 1ns / 1ps
// Shared types and codes for the sorted multiset table.
// No dependencies; used by smt_ctrl, smt_dp and sorted_multiset_table_top.
package smt_pkg;

   localparam int VALUE_W = 32;
   localparam int COUNT_W = 5;

   // request codes
   localparam logic [1:0] OP_INSERT = 2'd0;
   localparam logic [1:0] OP_DELETE = 2'd1;
   localparam logic [1:0] OP_DUMP   = 2'd2;
   localparam logic [1:0] OP_CLEAR  = 2'd3;

   // result status codes
   localparam logic [1:0] ST_OK    = 2'd0;
   localparam logic [1:0] ST_FULL  = 2'd1;
   localparam logic [1:0] ST_EMPTY = 2'd2;

   typedef struct packed {
      logic [1:0]                req_type;
      logic signed [VALUE_W-1:0] value;
   } req_item_type;

   typedef struct packed {
      logic signed [VALUE_W-1:0] value_out;
      logic [COUNT_W-1:0]        repeat_count;
      logic                      last;
      logic [1:0]                status;
      logic [COUNT_W-1:0]        size;
   } rsp_item_type;

   // controller -> datapath
   typedef struct packed {
      logic       load;       // capture request operand, clear dump counters
      logic       ins;        // insert request value in sorted position
      logic       clr;        // empty the table
      logic       del_step;   // remove one matching entry
      logic       dump_step;  // rotate chain by one, advance group count
      logic       emit;       // load the result register
      logic       grp;        // result carries the current dump group
      logic [1:0] status;
   } cmd_type;

   // datapath -> controller
   typedef struct packed {
      logic full;
      logic empty;
      logic match_any;
      logic grp_end;
      logic dump_last;
      logic slot_free;
   } sts_type;

endpackage

// ===== design/smt_ctrl.sv =====
`timescale 1ns / 1ps
// Controller state machine for the sorted multiset table.
// Depends on smt_pkg (cmd_type, sts_type, request and status codes).
module smt_ctrl (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_ready,
   input  logic [1:0]         req_op,
   input  smt_pkg::sts_type   sts,
   output smt_pkg::cmd_type   cmd
);

   localparam logic [1:0] S_IDLE = 2'd0;
   localparam logic [1:0] S_DEL  = 2'd1;
   localparam logic [1:0] S_DUMP = 2'd2;

   logic [1:0] state_ff, state_in;

   assign req_ready = (state_ff == S_IDLE) && sts.slot_free;

   always_comb begin
      cmd      = '0;
      state_in = state_ff;
      case (state_ff)
         S_IDLE: begin
            if (req_valid && sts.slot_free) begin
               cmd.load = 1'b1;
               case (req_op)
                  smt_pkg::OP_INSERT: begin
                     cmd.ins    = !sts.full;
                     cmd.emit   = 1'b1;
                     cmd.status = sts.full ? smt_pkg::ST_FULL : smt_pkg::ST_OK;
                  end
                  smt_pkg::OP_DELETE: begin
                     state_in = S_DEL;
                  end
                  smt_pkg::OP_DUMP: begin
                     if (sts.empty) begin
                        cmd.emit   = 1'b1;
                        cmd.status = smt_pkg::ST_EMPTY;
                     end else begin
                        state_in = S_DUMP;
                     end
                  end
                  default: begin
                     cmd.clr  = 1'b1;
                     cmd.emit = 1'b1;
                  end
               endcase
            end
         end
         S_DEL: begin
            if (sts.match_any) begin
               cmd.del_step = 1'b1;
            end else if (sts.slot_free) begin
               cmd.emit = 1'b1;
               state_in = S_IDLE;
            end
         end
         S_DUMP: begin
            // a step that closes a group must find the result register free
            if (!sts.grp_end || sts.slot_free) begin
               cmd.dump_step = 1'b1;
               cmd.emit      = sts.grp_end;
               cmd.grp       = sts.grp_end;
               if (sts.dump_last) begin
                  state_in = S_IDLE;
               end
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

// ===== design/smt_dp.sv =====
`timescale 1ns / 1ps
// Datapath of the sorted multiset table: entry shift chain, occupancy,
// dump counters and the result register. Depends on smt_pkg.
module smt_dp #(
   parameter int DEPTH = 16,
   parameter int WIDTH = 32
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic [smt_pkg::VALUE_W-1:0]   req_value,
   input  smt_pkg::cmd_type              cmd,
   output smt_pkg::sts_type              sts,
   input  logic                          rsp_ready,
   output logic                          rsp_valid,
   output smt_pkg::rsp_item_type         rsp_data
);

   localparam int OCC_W = $clog2(DEPTH + 1);
   localparam int VW    = smt_pkg::VALUE_W;
   localparam int CW    = smt_pkg::COUNT_W;

   logic [WIDTH-1:0] ent_ff [DEPTH];
   logic [WIDTH-1:0] ent_in [DEPTH];
   logic [WIDTH-1:0] v_ff, v_req;
   logic [OCC_W-1:0] occ_ff, occ_in, last_idx;
   logic [OCC_W-1:0] step_ff, step_in, cnt_ff, cnt_in;
   logic [DEPTH-1:0] lt_req, match;
   logic [DEPTH-2:0] ge_del;
   logic             rsp_valid_ff, rsp_valid_in;
   smt_pkg::rsp_item_type rsp_data_ff, rsp_data_in;

   // operand is WIDTH bits; upper bits zero when WIDTH exceeds the field
   assign v_req    = WIDTH'(req_value);
   assign last_idx = occ_ff - 1'b1;

   always_comb begin
      for (int i = 0; i < DEPTH; i++) begin
         lt_req[i] = (OCC_W'(i) < occ_ff) && ($signed(ent_ff[i]) < $signed(v_req));
         match[i]  = (OCC_W'(i) < occ_ff) && (ent_ff[i] == v_ff);
      end
      for (int i = 0; i < DEPTH - 1; i++) begin
         ge_del[i] = !($signed(ent_ff[i]) < $signed(v_ff));
      end
   end

   assign sts.full      = (occ_ff == OCC_W'(DEPTH));
   assign sts.empty     = (occ_ff == '0);
   assign sts.match_any = |match;
   assign sts.dump_last = (step_ff == last_idx);
   assign sts.grp_end   = (step_ff == last_idx) || (ent_ff[1] != ent_ff[0]);
   assign sts.slot_free = !rsp_valid_ff || rsp_ready;

   // entry chain
   always_comb begin
      for (int i = 0; i < DEPTH; i++) begin
         ent_in[i] = ent_ff[i];
      end
      if (cmd.ins) begin
         // entries below the insert point stay, the rest move up one place
         ent_in[0] = lt_req[0] ? ent_ff[0] : v_req;
         for (int i = 1; i < DEPTH; i++) begin
            if (!lt_req[i]) begin
               ent_in[i] = lt_req[i-1] ? v_req : ent_ff[i-1];
            end
         end
      end else if (cmd.del_step) begin
         // first entry not below the operand is the first match
         for (int i = 0; i < DEPTH - 1; i++) begin
            if (ge_del[i]) begin
               ent_in[i] = ent_ff[i+1];
            end
         end
      end else if (cmd.dump_step) begin
         // rotate the occupied part left; occupancy steps restore the order
         for (int i = 0; i < DEPTH - 1; i++) begin
            ent_in[i] = (OCC_W'(i) == last_idx) ? ent_ff[0] : ent_ff[i+1];
         end
         if (OCC_W'(DEPTH - 1) == last_idx) begin
            ent_in[DEPTH-1] = ent_ff[0];
         end
      end
   end

   always_comb begin
      occ_in = occ_ff;
      if (cmd.clr) begin
         occ_in = '0;
      end else if (cmd.ins) begin
         occ_in = occ_ff + 1'b1;
      end else if (cmd.del_step) begin
         occ_in = occ_ff - 1'b1;
      end
   end

   always_comb begin
      step_in = step_ff;
      cnt_in  = cnt_ff;
      if (cmd.load) begin
         step_in = '0;
         cnt_in  = '0;
      end else if (cmd.dump_step) begin
         step_in = step_ff + 1'b1;
         cnt_in  = sts.grp_end ? '0 : cnt_ff + 1'b1;
      end
   end

   // result register
   always_comb begin
      rsp_data_in  = rsp_data_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      if (cmd.emit) begin
         rsp_valid_in             = 1'b1;
         rsp_data_in.value_out    = cmd.grp ? VW'($signed(ent_ff[0])) : '0;
         rsp_data_in.repeat_count = cmd.grp ? CW'(cnt_ff + 1'b1) : '0;
         rsp_data_in.last         = cmd.grp ? sts.dump_last : 1'b1;
         rsp_data_in.status       = cmd.status;
         rsp_data_in.size         = CW'(occ_in);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         occ_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         occ_ff       <= occ_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      for (int i = 0; i < DEPTH; i++) begin
         ent_ff[i] <= ent_in[i];
      end
      step_ff     <= step_in;
      cnt_ff      <= cnt_in;
      rsp_data_ff <= rsp_data_in;
      if (cmd.load) begin
         v_ff <= v_req;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

endmodule

// ===== design/sorted_multiset_table_top.sv =====
`timescale 1ns / 1ps
// Top level of the sorted multiset table: controller plus datapath.
// Depends on smt_pkg, smt_ctrl and smt_dp.
//
// Usage:
//  - req channel (req_valid/req_ready/req_data) takes one request per
//    transfer: insert, delete all equal, dump grouped, clear.
//  - rsp channel (rsp_valid/rsp_ready/rsp_data) gives the results. Every
//    request gives exactly one result with last set, except a dump of a
//    non-empty table, which gives one result per distinct value in
//    ascending order, last set on the final one.
//  - One request is worked at a time; req_ready drops while it runs.
//  - Insert and clear: result valid the cycle after the transfer.
//  - Delete: one step per removed entry, then the result.
//  - Dump: one step per held entry (walking the entry chain by rotation).
//  - The result register is the only buffer toward the receiver. When
//    rsp_ready is low and a result is held, a step that must emit waits;
//    a new request is taken in the cycle that result leaves.
//  - Reset empties the table and drops any pending result. No clearing
//    pass: entries past the occupancy count never affect a result.
//  - size and repeat_count carry the low five bits of the counts.
module sorted_multiset_table_top #(
   parameter int DEPTH = 16,
   parameter int WIDTH = 32
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_ready,
   input  smt_pkg::req_item_type req_data,
   output logic                  rsp_valid,
   input  logic                  rsp_ready,
   output smt_pkg::rsp_item_type rsp_data
);

   smt_pkg::cmd_type cmd;
   smt_pkg::sts_type sts;

   smt_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_op    (req_data.req_type),
      .sts       (sts),
      .cmd       (cmd)
   );

   smt_dp #(
      .DEPTH (DEPTH),
      .WIDTH (WIDTH)
   ) u_dp (
      .clock     (clock),
      .reset     (reset),
      .req_value (req_data.value),
      .cmd       (cmd),
      .sts       (sts),
      .rsp_ready (rsp_ready),
      .rsp_valid (rsp_valid),
      .rsp_data  (rsp_data)
   );

   // a new result never overwrites one still waiting
   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      cmd.emit |-> sts.slot_free)
      else $error("result register overwritten");

   // a request transfer only happens when the result slot drains
   a_req_slot: assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready) |-> (!rsp_valid || rsp_ready))
      else $error("request taken with result pending");

   // insert and clear answer in the next cycle with a single final result
   a_single_rsp: assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready && (req_data.req_type == smt_pkg::OP_INSERT ||
                                  req_data.req_type == smt_pkg::OP_CLEAR))
      |=> (rsp_valid && rsp_data.last && rsp_data.repeat_count == '0))
      else $error("insert or clear result missing");

   // empty-dump result reports an empty table
   a_empty_dump: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_data.status == smt_pkg::ST_EMPTY)
      |-> (rsp_data.size == '0 && rsp_data.last))
      else $error("empty dump result inconsistent");

endmodule
